@@ hdl/ftpp_pkg.sv @@
// Shared types and constants for the file transfer packet parser.
// No dependencies; every file of the block but ftpp_fifo imports this package.
package ftpp_pkg;

  // Packet type codes, first byte of each packet
  localparam logic [7:0] TYPE_DATA  = 8'd1;
  localparam logic [7:0] TYPE_START = 8'd2;
  localparam logic [7:0] TYPE_END   = 8'd3;

  localparam int unsigned POS_W  = 17;
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
  localparam logic [7:0] SEQ_MOD = 8'd255;

  // First payload offset in a data packet (type, seq, len hi, len lo)
  localparam logic [POS_W-1:0] PAY_START = 17'd4;

  // Default depth of the command queue between front and back
  localparam int unsigned CMD_Q_DEPTH = 2;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_NAME    = 2'd2
  } kind_e_t;

  typedef enum logic [2:0] {
    ST_OPEN     = 3'd0,
    ST_START    = 3'd1,
    ST_DATA_OK  = 3'd2,
    ST_SEQ_BAD  = 3'd3,
    ST_END      = 3'd4,
    ST_BAD_TYPE = 3'd5
  } status_e_t;

  // What the back end does to the size accumulator
  typedef enum logic [1:0] {
    SZ_NONE  = 2'd0,
    SZ_CLEAR = 2'd1,
    SZ_SHIFT = 2'd2
  } size_op_e_t;

  // One classified word handed from front to back
  typedef struct packed {
    kind_e_t    kind;
    logic [7:0] data;
    status_e_t  status;
    size_op_e_t size_op;
    logic [7:0] exp_seq;
  } cmd_t;

endpackage

@@ hdl/ftpp_fifo.sv @@
// Small register-based FIFO used as the command queue between front and back.
// Generic width and depth; no package dependency.
module ftpp_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full    = (cnt_r == CNT_FULL);
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

@@ hdl/ftpp_front.sv @@
// Front end: tracks packet position and fields, classifies each input word.
// Depends on ftpp_pkg; feeds cmd_t words into the command queue.
module ftpp_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic [7:0]    pkt_byte,
  input  logic          last_byte,
  output ftpp_pkg::cmd_t cmd
);
  import ftpp_pkg::*;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       type_r, type_nxt;
  logic [7:0]       seq_r, seq_nxt;
  logic             match_r, match_nxt;
  logic [15:0]      plen_r, plen_nxt;
  logic [7:0]       slen_r, slen_nxt;
  logic [7:0]       nlen_r, nlen_nxt;
  logic             fin_r, fin_nxt;

  logic [POS_W-1:0] pay_off;
  logic [9:0]       size_hi, nlen_pos, name_lo, name_hi;
  logic [7:0]       cur_type;

  // Data payload offset; control packet field bounds from the size and name length bytes
  assign pay_off  = pos_r - PAY_START;
  assign size_hi  = 10'(slen_r) + 10'd3;
  assign nlen_pos = 10'(slen_r) + 10'd4;
  assign name_lo  = 10'(slen_r) + 10'd5;
  assign name_hi  = name_lo + 10'(nlen_r);

  always_comb begin
    pos_nxt      = pos_r;
    type_nxt     = type_r;
    seq_nxt      = seq_r;
    match_nxt    = match_r;
    plen_nxt     = plen_r;
    slen_nxt     = slen_r;
    nlen_nxt     = nlen_r;
    fin_nxt      = fin_r;
    cur_type     = type_r;
    cmd.kind     = KIND_NONE;
    cmd.data     = pkt_byte;
    cmd.status   = ST_OPEN;
    cmd.size_op  = SZ_NONE;

    if (accept && !fin_r) begin
      if (pos_r == '0) begin
        type_nxt  = pkt_byte;
        cur_type  = pkt_byte;
        match_nxt = 1'b0;
        plen_nxt  = '0;
        slen_nxt  = '0;
        nlen_nxt  = '0;
      end else if (type_r == TYPE_DATA) begin
        if (pos_r == 17'd1) begin
          match_nxt = (pkt_byte == seq_r);
        end else if (pos_r == 17'd2) begin
          plen_nxt = {pkt_byte, 8'h00};
        end else if (pos_r == 17'd3) begin
          plen_nxt = plen_r + {8'h00, pkt_byte};
        end else if (match_r && (pay_off < {1'b0, plen_r})) begin
          cmd.kind = KIND_PAYLOAD;
        end
      end else if (type_r == TYPE_START || type_r == TYPE_END) begin
        if (pos_r == 17'd2) begin
          slen_nxt    = pkt_byte;
          cmd.size_op = SZ_CLEAR;
        end else if (pos_r >= 17'd3 && pos_r < 17'(size_hi)) begin
          cmd.size_op = SZ_SHIFT;
        end else if (pos_r >= 17'd3 && pos_r == 17'(nlen_pos)) begin
          nlen_nxt = pkt_byte;
        end else if (pos_r >= 17'(name_lo) && pos_r < 17'(name_hi)) begin
          cmd.kind = KIND_NAME;
        end
      end

      if (last_byte) begin
        if (cur_type == TYPE_START) begin
          cmd.status = ST_START;
        end else if (cur_type == TYPE_DATA) begin
          if (match_nxt) begin
            cmd.status = ST_DATA_OK;
            seq_nxt    = (seq_r >= SEQ_MOD - 8'd1) ? '0 : seq_r + 8'd1;
          end else begin
            cmd.status = ST_SEQ_BAD;
          end
        end else if (cur_type == TYPE_END) begin
          cmd.status = ST_END;
          fin_nxt    = 1'b1;
        end else begin
          cmd.status = ST_BAD_TYPE;
        end
        pos_nxt = '0;
      end else if (pos_r != POS_MAX) begin
        pos_nxt = pos_r + 1'b1;
      end
    end

    cmd.exp_seq = seq_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      type_r  <= '0;
      seq_r   <= '0;
      match_r <= 1'b0;
      plen_r  <= '0;
      slen_r  <= '0;
      nlen_r  <= '0;
      fin_r   <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      type_r  <= type_nxt;
      seq_r   <= seq_nxt;
      match_r <= match_nxt;
      plen_r  <= plen_nxt;
      slen_r  <= slen_nxt;
      nlen_r  <= nlen_nxt;
      fin_r   <= fin_nxt;
    end
  end

endmodule

@@ hdl/ftpp_back.sv @@
// Back end: runs the file size accumulator and holds the result register.
// Depends on ftpp_pkg; drains cmd_t words from the command queue.
module ftpp_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  ftpp_pkg::cmd_t q_data,
  output logic           q_pop,
  input  logic           pop,
  output logic           empty,
  output logic [1:0]     byte_kind,
  output logic [7:0]     out_byte,
  output logic [2:0]     packet_status,
  output logic [31:0]    xfer_size,
  output logic [7:0]     expected_seq
);
  import ftpp_pkg::*;

  logic        valid_r, valid_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [1:0]  kind_r;
  logic [7:0]  byte_r;
  logic [2:0]  status_r;
  logic [7:0]  seq_r;
  logic        slot_free;

  assign slot_free = !valid_r || pop;
  assign q_pop     = !q_empty && slot_free;

  always_comb begin
    valid_nxt = valid_r;
    acc_nxt   = acc_r;
    if (q_pop) begin
      valid_nxt = 1'b1;
      unique case (q_data.size_op)
        SZ_NONE:  acc_nxt = acc_r;
        SZ_CLEAR: acc_nxt = '0;
        SZ_SHIFT: acc_nxt = {acc_r[23:0], q_data.data};
        default:  acc_nxt = acc_r;
      endcase
    end else if (pop) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      acc_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      acc_r   <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      kind_r   <= q_data.kind;
      byte_r   <= (q_data.kind == KIND_NONE) ? 8'h00 : q_data.data;
      status_r <= q_data.status;
      seq_r    <= q_data.exp_seq;
    end
  end

  // acc_r only moves when a new result loads, so it tracks the held result
  assign empty         = !valid_r;
  assign byte_kind     = kind_r;
  assign out_byte      = byte_r;
  assign packet_status = status_r;
  assign xfer_size     = acc_r;
  assign expected_seq  = seq_r;

endmodule

@@ hdl/file_transfer_packet_parser.sv @@
// Top level of the file transfer packet parser: front, command queue, back.
// Depends on ftpp_pkg, ftpp_front, ftpp_fifo and ftpp_back.
//
//   channel   direction  handshake     payload
//   input     in         push / full   in_pkt_byte, in_last_byte
//   result    out        pop / empty   out_byte_kind, out_out_byte, out_packet_status,
//                                      out_xfer_size, out_expected_seq
//
// One word in, one result out; a new word is taken every cycle while full is low.
// Path from push to the result showing: front -> queue -> result reg.
// Reset is synchronous on rst_n low; it clears all parse state and empties both queues.
// A stalled pop backs up the command queue; full rises once it holds CMD_Q_DEPTH words.
// The accumulator lives in the back end, so out_xfer_size follows the result being shown.
module file_transfer_packet_parser #(
  parameter int unsigned CMD_Q_DEPTH = ftpp_pkg::CMD_Q_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_pkt_byte,
  input  logic        in_last_byte,
  // result channel
  input  logic        pop,
  output logic        empty,
  output logic [1:0]  out_byte_kind,
  output logic [7:0]  out_out_byte,
  output logic [2:0]  out_packet_status,
  output logic [31:0] out_xfer_size,
  output logic [7:0]  out_expected_seq
);
  import ftpp_pkg::*;

  localparam int unsigned CMD_W = $bits(cmd_t);

  logic       in_acc;
  cmd_t       front_cmd;
  cmd_t       q_data;
  logic       q_empty;
  logic       q_pop;
  logic [CMD_W-1:0] q_rd_bits;

  // Word accepted when push is high and the queue has room
  assign in_acc = push && !full;

  // Front: position counter and field decode; writes one command per word
  ftpp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_acc),
    .pkt_byte  (in_pkt_byte),
    .last_byte (in_last_byte),
    .cmd       (front_cmd)
  );

  // Command queue decouples the front from a stalled result port
  ftpp_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (CMD_Q_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_acc),
    .wr_data (front_cmd),
    .full    (full),
    .rd_en   (q_pop),
    .rd_data (q_rd_bits),
    .empty   (q_empty)
  );

  assign q_data = cmd_t'(q_rd_bits);

  // Back: size accumulator and result register
  ftpp_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_data        (q_data),
    .q_pop         (q_pop),
    .pop           (pop),
    .empty         (empty),
    .byte_kind     (out_byte_kind),
    .out_byte      (out_out_byte),
    .packet_status (out_packet_status),
    .xfer_size     (out_xfer_size),
    .expected_seq  (out_expected_seq)
  );

endmodule

@@ hdl/ftpp_chk.sv @@
// Port-level checker for the file transfer packet parser, bound to the top.
// Depends on ftpp_pkg and file_transfer_packet_parser.
module ftpp_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        push,
  input logic        full,
  input logic [7:0]  in_pkt_byte,
  input logic        in_last_byte,
  input logic        pop,
  input logic        empty,
  input logic [1:0]  out_byte_kind,
  input logic [7:0]  out_out_byte,
  input logic [2:0]  out_packet_status,
  input logic [31:0] out_xfer_size,
  input logic [7:0]  out_expected_seq
);
  import ftpp_pkg::*;

  logic end_seen_r;

  // Set once an end-done result has been taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      end_seen_r <= 1'b0;
    end else if (pop && !empty && out_packet_status == ST_END) begin
      end_seen_r <= 1'b1;
    end
  end

  a_rst_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  a_idle_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_byte_kind == KIND_NONE) |-> out_out_byte == 8'h00)
    else $error("byte shown with no byte kind");

  a_kind_status: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_byte_kind != KIND_NONE) |->
      ((out_byte_kind == KIND_PAYLOAD &&
        (out_packet_status == ST_OPEN || out_packet_status == ST_DATA_OK)) ||
       (out_byte_kind == KIND_NAME &&
        (out_packet_status == ST_OPEN || out_packet_status == ST_START ||
         out_packet_status == ST_END))))
    else $error("byte kind does not fit packet status");

  a_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && end_seen_r) |->
      (out_byte_kind == KIND_NONE && out_packet_status == ST_OPEN))
    else $error("activity after end of transfer");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_out_byte) &&
      $stable(out_packet_status) && $stable(out_xfer_size)))
    else $error("stalled result changed");

endmodule

bind file_transfer_packet_parser ftpp_chk u_ftpp_chk (.*);
